>>> rtl/esd_pkg.sv
// esd_pkg: shared types and character constants for the escape sequence decoder
`default_nettype none

package esd_pkg;

    // decoder modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_OCT1   = 3'd2,
        MODE_OCT2   = 3'd3,
        MODE_HEX0   = 3'd4,
        MODE_HEX1   = 3'd5
    } mode_t;

    // width of the count field on the result channel
    localparam int unsigned BYTES_W = 16;

    // characters
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LV    = 8'h76;

    // up to two decoded bytes produced by one character
    typedef struct packed {
        logic       v0;
        logic [7:0] byte0;
        logic       last0;
        logic       v1;
        logic [7:0] byte1;
        logic       last1;
    } dec_out_t;

    // one queued result item
    typedef struct packed {
        logic               last;
        logic [BYTES_W-1:0] cnt;
        logic [7:0]         data;
    } res_entry_t;

endpackage

`default_nettype wire

>>> rtl/escape_sequence_decoder.sv
// escape_sequence_decoder: top level, state registers and result queue
//
// Decodes a backslash-escaped string, one character per input item, into
// decoded bytes. Each accepted character is decoded in the same cycle and
// yields zero, one or two result items, which enter a four-entry result
// queue; s_tready is high while the queue has at least two free entries,
// so a character can be accepted every cycle while it is high. The result
// side delivers at most one item per cycle, so a long run of characters
// that each yield two bytes is paced by the result port. Results reach the
// master side from the registered queue. The byte count restarts at each
// string and holds at 2^COUNT_WIDTH - 1; bytes_so_far shows its low 16 bits.
`default_nettype none

module escape_sequence_decoder #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_in[7:0]
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // byte_out[7:0], bytes_so_far[23:8]
    output logic             m_tlast    // last_out
);

    localparam int unsigned XW = (COUNT_WIDTH > esd_pkg::BYTES_W) ?
                                 COUNT_WIDTH : esd_pkg::BYTES_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    esd_pkg::mode_t          mode_reg;
    esd_pkg::mode_t          mode_next;
    logic [7:0]              partial_reg;
    logic [7:0]              partial_next;
    logic [COUNT_WIDTH-1:0]  cnt_reg;
    logic [COUNT_WIDTH-1:0]  cnt_next;
    logic [COUNT_WIDTH-1:0]  cnt1;
    logic [COUNT_WIDTH-1:0]  cnt2;
    logic [XW-1:0]           cnt1_w;
    logic [XW-1:0]           cnt2_w;
    esd_pkg::dec_out_t       res;

    esd_pkg::res_entry_t     q_reg [4];
    logic [1:0]              wr_ptr_reg;
    logic [1:0]              wr_ptr_next;
    logic [1:0]              rd_ptr_reg;
    logic [1:0]              rd_ptr_next;
    logic [2:0]              fill_reg;
    logic [2:0]              fill_next;
    logic                    push;
    logic                    pop;
    logic [1:0]              wr_ptr_p1;

    esd_decode u_decode (
        .mode         (mode_reg),
        .partial      (partial_reg),
        .char_in      (s_tdata),
        .last_char    (s_tlast),
        .mode_next    (mode_next),
        .partial_next (partial_next),
        .res          (res)
    );

    // handshakes
    assign s_tready = (fill_reg <= 3'd2);
    assign push     = s_tvalid && s_tready;
    assign m_tvalid = (fill_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;

    // saturating counts for the first and second byte of this item
    always_comb begin
        cnt1   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNT_WIDTH'(1);
        cnt2   = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + COUNT_WIDTH'(1);
        cnt1_w = XW'(cnt1);
        cnt2_w = XW'(cnt2);
        if (s_tlast) begin
            cnt_next = '0;
        end else if (res.v1) begin
            cnt_next = cnt2;
        end else if (res.v0) begin
            cnt_next = cnt1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= esd_pkg::MODE_NORMAL;
            partial_reg <= 8'd0;
            cnt_reg     <= '0;
        end else if (push) begin
            mode_reg    <= mode_next;
            partial_reg <= partial_next;
            cnt_reg     <= cnt_next;
        end
    end

    // queue pointers and fill
    always_comb begin
        wr_ptr_p1   = wr_ptr_reg + 2'd1;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (push && res.v1) begin
            wr_ptr_next = wr_ptr_reg + 2'd2;
            fill_next   = fill_reg + 3'd2;
        end else if (push && res.v0) begin
            wr_ptr_next = wr_ptr_p1;
            fill_next   = fill_reg + 3'd1;
        end
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        if (pop) begin
            fill_next = fill_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            fill_reg   <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push && res.v0) begin
            q_reg[wr_ptr_reg].data <= res.byte0;
            q_reg[wr_ptr_reg].last <= res.last0;
            q_reg[wr_ptr_reg].cnt  <= cnt1_w[esd_pkg::BYTES_W-1:0];
        end
        if (push && res.v1) begin
            q_reg[wr_ptr_p1].data <= res.byte1;
            q_reg[wr_ptr_p1].last <= res.last1;
            q_reg[wr_ptr_p1].cnt  <= cnt2_w[esd_pkg::BYTES_W-1:0];
        end
    end

    // result port
    assign m_tdata = {q_reg[rd_ptr_reg].cnt, q_reg[rd_ptr_reg].data};
    assign m_tlast = q_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

>>> rtl/esd_decode.sv
// esd_decode: per-character decode of the escape state machine
`default_nettype none

module esd_decode (
    input  var esd_pkg::mode_t    mode,
    input  wire logic [7:0]       partial,
    input  wire logic [7:0]       char_in,
    input  wire logic             last_char,
    output var esd_pkg::mode_t    mode_next,
    output logic      [7:0]       partial_next,
    output var esd_pkg::dec_out_t res
);

    logic [7:0] dig;
    logic       is_oct;
    logic       hex_ok;
    logic [3:0] hex_v;
    logic [7:0] oct_acc;
    logic [7:0] hex_acc;
    logic       ctrl_hit;
    logic [7:0] ctrl_byte;
    logic       plain_emit;
    esd_pkg::mode_t plain_mode;

    // character classes
    always_comb begin
        dig        = char_in - esd_pkg::CH_ZERO;
        is_oct     = (char_in >= esd_pkg::CH_ZERO) && (char_in <= esd_pkg::CH_SEVEN);
        hex_ok     = 1'b1;
        hex_v      = dig[3:0];
        if ((char_in >= esd_pkg::CH_ZERO) && (char_in <= esd_pkg::CH_NINE)) begin
            hex_v = dig[3:0];
        end else if ((char_in >= esd_pkg::CH_LA) && (char_in <= esd_pkg::CH_LF)) begin
            hex_v = 4'(char_in - esd_pkg::CH_LA + 8'd10);
        end else if ((char_in >= esd_pkg::CH_UA) && (char_in <= esd_pkg::CH_UF)) begin
            hex_v = 4'(char_in - esd_pkg::CH_UA + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
        oct_acc    = {partial[4:0], dig[2:0]};
        hex_acc    = {partial[3:0], hex_v};
        plain_emit = !((char_in == esd_pkg::CH_BSL) && !last_char);
        plain_mode = plain_emit ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_ESC;
    end

    // single-letter control escapes
    always_comb begin
        ctrl_hit  = 1'b1;
        ctrl_byte = char_in;
        unique case (char_in)
            esd_pkg::CH_LN: ctrl_byte = esd_pkg::CH_NL;
            esd_pkg::CH_LR: ctrl_byte = esd_pkg::CH_CR;
            esd_pkg::CH_LT: ctrl_byte = esd_pkg::CH_TAB;
            esd_pkg::CH_LB: ctrl_byte = esd_pkg::CH_BS;
            esd_pkg::CH_LV: ctrl_byte = esd_pkg::CH_VT;
            esd_pkg::CH_LF: ctrl_byte = esd_pkg::CH_FF;
            default:        ctrl_hit  = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        mode_next    = plain_mode;
        partial_next = partial;
        unique case (mode)
            esd_pkg::MODE_ESC: begin
                if (ctrl_hit) begin
                    mode_next = esd_pkg::MODE_NORMAL;
                end else if (is_oct) begin
                    partial_next = {5'd0, dig[2:0]};
                    mode_next    = last_char ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_OCT1;
                end else if (char_in == esd_pkg::CH_X) begin
                    mode_next = last_char ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_HEX0;
                end else begin
                    mode_next = esd_pkg::MODE_NORMAL;
                end
            end
            esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: begin
                if (is_oct) begin
                    partial_next = oct_acc;
                    mode_next    = (last_char || (mode == esd_pkg::MODE_OCT2)) ?
                                   esd_pkg::MODE_NORMAL : esd_pkg::MODE_OCT2;
                end
            end
            esd_pkg::MODE_HEX0: begin
                if (hex_ok) begin
                    partial_next = {4'd0, hex_v};
                    mode_next    = last_char ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_HEX1;
                end
            end
            esd_pkg::MODE_HEX1: begin
                if (hex_ok) begin
                    partial_next = hex_acc;
                    mode_next    = esd_pkg::MODE_NORMAL;
                end
            end
            default: begin
                mode_next = plain_mode;
            end
        endcase
        // end of string starts the next one fresh
        if (last_char) begin
            mode_next    = esd_pkg::MODE_NORMAL;
            partial_next = 8'd0;
        end
    end

    // decoded bytes
    always_comb begin
        res = '0;
        unique case (mode)
            esd_pkg::MODE_ESC: begin
                res.last0 = last_char;
                if (ctrl_hit) begin
                    res.v0    = 1'b1;
                    res.byte0 = ctrl_byte;
                end else if (is_oct) begin
                    res.v0    = last_char;
                    res.byte0 = {5'd0, dig[2:0]};
                end else if (char_in == esd_pkg::CH_X) begin
                    res.v0    = last_char;
                    res.byte0 = esd_pkg::CH_X;
                end else begin
                    res.v0    = 1'b1;
                    res.byte0 = char_in;
                end
            end
            esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: begin
                if (is_oct) begin
                    res.v0    = last_char || (mode == esd_pkg::MODE_OCT2);
                    res.byte0 = oct_acc;
                    res.last0 = last_char;
                end else begin
                    res.v0    = 1'b1;
                    res.byte0 = partial;
                    res.v1    = plain_emit;
                    res.byte1 = char_in;
                    res.last1 = last_char;
                end
            end
            esd_pkg::MODE_HEX0: begin
                if (hex_ok) begin
                    res.v0    = last_char;
                    res.byte0 = {4'd0, hex_v};
                    res.last0 = 1'b1;
                end else begin
                    res.v0    = 1'b1;
                    res.byte0 = esd_pkg::CH_X;
                    res.v1    = plain_emit;
                    res.byte1 = char_in;
                    res.last1 = last_char;
                end
            end
            esd_pkg::MODE_HEX1: begin
                if (hex_ok) begin
                    res.v0    = 1'b1;
                    res.byte0 = hex_acc;
                    res.last0 = last_char;
                end else begin
                    res.v0    = 1'b1;
                    res.byte0 = partial;
                    res.v1    = plain_emit;
                    res.byte1 = char_in;
                    res.last1 = last_char;
                end
            end
            default: begin
                res.v0    = plain_emit;
                res.byte0 = char_in;
                res.last0 = last_char;
            end
        endcase
    end

endmodule

`default_nettype wire
